FILE: rtl/pvi_pkg.sv
`default_nettype none
package pvi_pkg;

    localparam int FRAC_BITS    = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int SCALE_FRAC   = 48;
    localparam int ANG_FRAC     = 30;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MASS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

    localparam logic [2:0] FUNC_KICK_DRIFT = 3'd0;
    localparam logic [2:0] FUNC_KICK       = 3'd1;
    localparam logic [2:0] FUNC_ROTATE     = 3'd2;
    localparam logic [2:0] FUNC_LOAD_POS   = 3'd3;
    localparam logic [2:0] FUNC_LOAD_VEL   = 3'd4;

    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [63:0] vec_x;
        logic signed [63:0] vec_y;
        logic signed [63:0] vec_z;
        logic signed [31:0] angle;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] pos_z;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
        logic               saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KICK_MUL,
        ST_KICK_DIV,
        ST_KICK_ADD,
        ST_SD_MUL,
        ST_DRIFT_MUL,
        ST_DRIFT_ADD,
        ST_CORDIC,
        ST_TURN_MUL,
        ST_TURN_ADD,
        ST_DONE
    } state_t;

    // product unit: 64x64 unsigned, 32x32 partial per cycle
    typedef struct packed {
        logic         start;
        logic [63:0]  a;
        logic [63:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] p;
    } mul_rsp_t;

    function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                7'd0: r = 34'sh3243F6A8;
                7'd1: r = 34'sh1DAC6705;
                7'd2: r = 34'sh0FADBAFC;
                7'd3: r = 34'sh07F56EA6;
                7'd4: r = 34'sh03FEAB76;
                7'd5: r = 34'sh01FFD55B;
                7'd6: r = 34'sh00FFFAAA;
                7'd7: r = 34'sh007FFF55;
                7'd8: r = 34'sh003FFFEA;
                7'd9: r = 34'sh001FFFFD;
                default:
                    if (i < 7'd30)
                        r = (34'sd1 <<< (7'd30 - i)) - 34'sd1;
                    else
                        r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] fit64(input logic [127:0] s, output logic clip);
        begin
            clip = (s[127:63] != {65{1'b0}}) && (s[127:63] != {65{1'b1}});
            if (!clip)
                return s[63:0];
            return s[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pvi_mul.sv
`default_nettype none
module pvi_mul
    import pvi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic [1:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic         done_reg, done_next;

    always_comb
    begin
        pa = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        pp_sh = 128'(pp) << (7'(step_reg[1]) * 7'd32 + 7'(step_reg[0]) * 7'd32);
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + pp_sh;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule
`default_nettype wire

FILE: rtl/particle_verlet_integrator_3d.sv
`default_nettype none
// Velocity Verlet integrator for one particle, Q32.32 state. One transfer
// in, one transfer out; in_stall is high from acceptance until the result is
// taken. Steps per item: kick runs, per axis, a multiply, a 128-step
// restoring divide and an add; kick-drift then scales by dt twice and runs
// two multiplies and one add per axis; rotate runs a CORDIC rotation, then
// 8 multiplies and 4 write-backs; loads go straight to the result. Products
// come from the 64x64 product unit; the divider yields one bit per cycle.
module particle_verlet_integrator_3d
    import pvi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_data
);

    state_t       state_reg, state_next;
    logic [63:0]  mass_reg, dt_reg, scale_reg;
    logic [63:0]  pos_reg [3];
    logic [63:0]  vel_reg [3];
    in_item_t     item_reg;
    logic         flag_reg;
    logic [1:0]   axis_reg;
    logic [1:0]   sub_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [127:0] num_reg, sd_reg, tmp_reg;
    logic [63:0]  rem_reg;
    logic         started_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic         flip_reg;
    logic [127:0] acc_reg [2];

    mul_req_t     mreq;
    mul_rsp_t     mrsp;

    pvi_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    // helpers
    logic [63:0]  cur_f, cur_fmag, cur_v, cur_vmag;
    logic         cur_fneg, cur_vneg;
    logic [64:0]  rem_sh;
    logic         div_take;
    logic [127:0] dv_mag, dr_mag, add_res, add_b;
    logic [63:0]  add_base, fit_res;
    logic         add_neg, fit_clip;
    logic signed [33:0] cdx, cdy, cang, z0;
    logic [63:0]  tv_a;
    logic signed [33:0] tv_c;
    logic         t_neg;
    logic [63:0]  t_amag, t_cmag;
    logic [127:0] t_prod_signed;
    logic [127:0] tsum_sh;
    logic [63:0]  tfit;
    logic         tclip;

    always_comb
    begin
        case (axis_reg)
            2'd0:    cur_f = item_reg.vec_x;
            2'd1:    cur_f = item_reg.vec_y;
            default: cur_f = item_reg.vec_z;
        endcase
        cur_fneg = cur_f[63];
        cur_fmag = cur_fneg ? (64'd0 - cur_f) : cur_f;
        cur_v    = vel_reg[axis_reg];
        cur_vneg = cur_v[63];
        cur_vmag = cur_vneg ? (64'd0 - cur_v) : cur_v;

        rem_sh   = {rem_reg, num_reg[127]};
        div_take = rem_sh >= {1'b0, mass_reg};

        dv_mag = (mass_reg == 64'd0) ? ((tmp_reg != '0) ? {64'd1, 64'd0} : '0)
                                     : {1'b0, num_reg[127:1]};
        dr_mag = tmp_reg;
        if (state_reg == ST_KICK_ADD)
        begin
            add_base = vel_reg[axis_reg];
            add_neg  = cur_fneg;
            add_b    = dv_mag;
        end
        else
        begin
            add_base = pos_reg[axis_reg];
            add_neg  = cur_vneg;
            add_b    = dr_mag;
        end
        if (add_b[127:64] != 64'd0)
            add_b = {64'd1, 64'd0};
        if (add_neg)
            add_b = 128'd0 - add_b;
        add_res = {{64{add_base[63]}}, add_base} + add_b;
        fit_res = fit64(add_res, fit_clip);

        cdx = cy_reg >>> cnt_reg;
        cdy = cx_reg >>> cnt_reg;
        cang = atan_q30(cnt_reg);
        z0 = 34'(signed'(item_reg.angle)) <<< 1;

        // turn: sub_reg selects term: 0 v0*c, 1 v1*s, 2 v0*s, 3 v1*c
        tv_a = sub_reg[0] ? (axis_reg[0] ? vel_reg[1] : pos_reg[1])
                          : (axis_reg[0] ? vel_reg[0] : pos_reg[0]);
        tv_c = (sub_reg == 2'd0 || sub_reg == 2'd3) ? cx_reg : cy_reg;
        t_amag = tv_a[63] ? (64'd0 - tv_a) : tv_a;
        t_cmag = tv_c[33] ? 64'(-tv_c) : 64'(tv_c);
        t_neg  = tv_a[63] ^ tv_c[33];
        t_prod_signed = t_neg ? (128'd0 - mrsp.p) : mrsp.p;
        tsum_sh = 128'($signed(acc_reg[0]) >>> ANG_FRAC);
        tfit = fit64(tsum_sh, tclip);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    case (in_data.func)
                        FUNC_KICK_DRIFT, FUNC_KICK: state_next = ST_KICK_MUL;
                        FUNC_ROTATE:                state_next = ST_CORDIC;
                        default:                    state_next = ST_DONE;
                    endcase
                end
            ST_KICK_MUL:
                if (mrsp.done)
                    state_next = ST_KICK_DIV;
            ST_KICK_DIV:
                if (mass_reg == 64'd0 || cnt_reg == 7'd127)
                    state_next = ST_KICK_ADD;
            ST_KICK_ADD:
                if (axis_reg != 2'd2)
                    state_next = ST_KICK_MUL;
                else if (item_reg.func == FUNC_KICK_DRIFT)
                    state_next = ST_SD_MUL;
                else
                    state_next = ST_DONE;
            ST_SD_MUL:
                if (mrsp.done && sub_reg == 2'd1)
                    state_next = ST_DRIFT_MUL;
            ST_DRIFT_MUL:
                if (mrsp.done && sub_reg == 2'd1)
                    state_next = ST_DRIFT_ADD;
            ST_DRIFT_ADD:
                state_next = (axis_reg == 2'd2) ? ST_DONE : ST_DRIFT_MUL;
            ST_CORDIC:
                if (cnt_reg == 7'(CORDIC_STEPS))
                    state_next = ST_TURN_MUL;
            ST_TURN_MUL:
                if (mrsp.done && sub_reg == 2'd3)
                    state_next = ST_TURN_ADD;
            ST_TURN_ADD:
                if (sub_reg == 2'd1)
                    state_next = (axis_reg == 2'd1) ? ST_DONE : ST_TURN_MUL;
            ST_DONE:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_DONE);
        mreq.start = 1'b0;
        mreq.a = '0;
        mreq.b = '0;
        if (!started_reg)
        begin
            case (state_reg)
                ST_KICK_MUL:
                begin
                    mreq.start = 1'b1;
                    mreq.a = cur_fmag;
                    mreq.b = dt_reg;
                end
                ST_SD_MUL:
                begin
                    mreq.start = 1'b1;
                    mreq.a = scale_reg;
                    mreq.b = dt_reg;
                end
                ST_DRIFT_MUL:
                begin
                    mreq.start = 1'b1;
                    mreq.a = sub_reg[0] ? sd_reg[127:64] : sd_reg[63:0];
                    mreq.b = cur_vmag;
                end
                ST_TURN_MUL:
                begin
                    mreq.start = 1'b1;
                    mreq.a = t_amag;
                    mreq.b = t_cmag;
                end
                default:
                begin
                    mreq.start = 1'b0;
                end
            endcase
        end
        out_data.pos_x = pos_reg[0];
        out_data.pos_y = pos_reg[1];
        out_data.pos_z = pos_reg[2];
        out_data.vel_x = vel_reg[0];
        out_data.vel_y = vel_reg[1];
        out_data.vel_z = vel_reg[2];
        out_data.saturated = flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mass_reg    <= 64'd4294967296;
            dt_reg      <= 64'd4294967296;
            scale_reg   <= 64'd1881544;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
                vel_reg[k] <= '0;
            end
            flag_reg    <= 1'b0;
            axis_reg    <= '0;
            sub_reg     <= '0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASS:  mass_reg  <= cfg_data;
                    CFG_DT:    dt_reg    <= cfg_data;
                    CFG_SCALE: scale_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (mreq.start)
                started_reg <= 1'b1;
            case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        item_reg    <= in_data;
                        flag_reg    <= 1'b0;
                        axis_reg    <= '0;
                        sub_reg     <= '0;
                        cnt_reg     <= '0;
                        started_reg <= 1'b0;
                        if (in_data.func == FUNC_LOAD_POS)
                        begin
                            pos_reg[0] <= in_data.vec_x;
                            pos_reg[1] <= in_data.vec_y;
                            pos_reg[2] <= in_data.vec_z;
                        end
                        if (in_data.func == FUNC_LOAD_VEL)
                        begin
                            vel_reg[0] <= in_data.vec_x;
                            vel_reg[1] <= in_data.vec_y;
                            vel_reg[2] <= in_data.vec_z;
                        end
                    end
                ST_KICK_MUL:
                    if (mrsp.done)
                    begin
                        num_reg <= mrsp.p;
                        tmp_reg <= mrsp.p;
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        started_reg <= 1'b0;
                    end
                ST_KICK_DIV:
                    if (mass_reg != 64'd0)
                    begin
                        rem_reg <= div_take ? 64'(rem_sh - {1'b0, mass_reg})
                                            : rem_sh[63:0];
                        num_reg <= {num_reg[126:0], div_take};
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                ST_KICK_ADD:
                begin
                    vel_reg[axis_reg] <= fit_res;
                    if (fit_clip)
                        flag_reg <= 1'b1;
                    axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    sub_reg  <= '0;
                end
                ST_SD_MUL, ST_DRIFT_MUL:
                    if (mrsp.done)
                    begin
                        started_reg <= 1'b0;
                        sub_reg <= (sub_reg == 2'd1) ? 2'd0 : sub_reg + 2'd1;
                        if (state_reg == ST_SD_MUL)
                            sd_reg <= mrsp.p;
                        else if (sub_reg == 2'd0)
                            acc_reg[0] <= mrsp.p;
                        else
                            acc_reg[1] <= mrsp.p;
                    end
                ST_DRIFT_ADD:
                begin
                    pos_reg[axis_reg] <= fit_res;
                    if (fit_clip)
                        flag_reg <= 1'b1;
                    axis_reg <= axis_reg + 2'd1;
                end
                ST_CORDIC:
                    if (cnt_reg == 7'd0 && !started_reg)
                    begin
                        started_reg <= 1'b1;
                        cx_reg <= GAIN_Q30;
                        cy_reg <= '0;
                        flip_reg <= 1'b0;
                        if (z0 > HALF_PI_Q30)
                        begin
                            cz_reg <= z0 - PI_Q30;
                            flip_reg <= 1'b1;
                        end
                        else if (z0 < -HALF_PI_Q30)
                        begin
                            cz_reg <= z0 + PI_Q30;
                            flip_reg <= 1'b1;
                        end
                        else
                            cz_reg <= z0;
                    end
                    else if (cnt_reg == 7'(CORDIC_STEPS))
                    begin
                        started_reg <= 1'b0;
                        cnt_reg <= '0;
                        acc_reg[0] <= '0;
                        acc_reg[1] <= '0;
                        if (flip_reg)
                        begin
                            cx_reg <= -cx_reg;
                            cy_reg <= -cy_reg;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                        if (!cz_reg[33])
                        begin
                            cx_reg <= cx_reg - cdx;
                            cy_reg <= cy_reg + cdy;
                            cz_reg <= cz_reg - cang;
                        end
                        else
                        begin
                            cx_reg <= cx_reg + cdx;
                            cy_reg <= cy_reg - cdy;
                            cz_reg <= cz_reg + cang;
                        end
                    end
                ST_TURN_MUL:
                    if (mrsp.done)
                    begin
                        started_reg <= 1'b0;
                        sub_reg <= sub_reg + 2'd1;
                        case (sub_reg)
                            2'd0:    acc_reg[0] <= t_prod_signed;
                            2'd1:    acc_reg[0] <= acc_reg[0] - t_prod_signed;
                            2'd2:    acc_reg[1] <= t_prod_signed;
                            default: acc_reg[1] <= acc_reg[1] + t_prod_signed;
                        endcase
                    end
                ST_TURN_ADD:
                begin
                    if (tclip)
                        flag_reg <= 1'b1;
                    if (sub_reg == 2'd0)
                    begin
                        sub_reg <= 2'd1;
                        if (axis_reg[0])
                            vel_reg[0] <= tfit;
                        else
                            pos_reg[0] <= tfit;
                        acc_reg[0] <= acc_reg[1];
                    end
                    else
                    begin
                        if (axis_reg[0])
                            vel_reg[1] <= tfit;
                        else
                            pos_reg[1] <= tfit;
                        sub_reg  <= '0;
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                default:
                    ;
            endcase
            if (state_reg == ST_DRIFT_MUL && mrsp.done && sub_reg == 2'd1)
                tmp_reg <= ({64'd0, acc_reg[0][127:64]} + mrsp.p) >> (SCALE_FRAC + FRAC_BITS - 64);
        end
    end

endmodule
`default_nettype wire
